// ===== hw/rtl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, codes, types and helpers of the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  // Store geometry and element width
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Fixed field widths of the request and result channels
  localparam int KIND_W = 2;
  localparam int FLD_W  = 3;
  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  // Request kinds; the fourth code is ignored
  localparam logic [KIND_W-1:0] KIND_WR_A    = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_WR_B    = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_COMPUTE = KIND_W'(2);

  // Controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             acc_clr;
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] rd_col;
    logic [IDX_W-1:0] rd_k;
  } imm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } imm_sts_t;

  // Zero counts as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // Keep the low ELEM_WIDTH bits, sign extended
  function automatic logic [DATA_W-1:0] sext_elem(input logic [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] s;
    s = $signed(v << (DATA_W - ELEM_WIDTH));
    return DATA_W'(s >>> (DATA_W - ELEM_WIDTH));
  endfunction

endpackage

// ===== hw/rtl/imm_ifs.sv =====
// ----------------------------------------------------------------------------
// imm request and result channels
// Valid/ready channels carrying element writes, compute requests and results.
// ----------------------------------------------------------------------------
interface imm_in_if;
  import imm_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [FLD_W-1:0]  row;
  logic [FLD_W-1:0]  col;
  logic [DATA_W-1:0] value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface imm_out_if;
  import imm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] product;
  logic [FLD_W-1:0]  out_row;
  logic [FLD_W-1:0]  out_col;
  logic              last;

  modport source (output valid, product, out_row, out_col, last, input ready);
  modport sink   (input valid, product, out_row, out_col, last, output ready);
endinterface

// ===== hw/rtl/imm_datapath.sv =====
// ----------------------------------------------------------------------------
// imm_datapath
// Element stores, read/multiply/accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module imm_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  imm_pkg::imm_cmd_t        cmd_i,
  output imm_pkg::imm_sts_t        sts_o,
  input  logic [imm_pkg::FLD_W-1:0]  wr_row_i,
  input  logic [imm_pkg::FLD_W-1:0]  wr_col_i,
  input  logic [imm_pkg::DATA_W-1:0] wr_value_i,
  output logic [imm_pkg::DATA_W-1:0] product_o
);
  import imm_pkg::*;

  logic [DATA_W-1:0] store_a [DEPTH];
  logic [DATA_W-1:0] store_b [DEPTH];

  logic              wr_in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [DATA_W-1:0] a_rd_q, b_rd_q;
  logic [DATA_W-1:0] mul_d, mul_q;
  logic [DATA_W-1:0] acc_d, acc_q;
  logic              rd_vld_q, mul_vld_q;

  // writes outside the store are dropped
  assign wr_in_range = (int'(wr_row_i) < MAX_DIM) && (int'(wr_col_i) < MAX_DIM);
  assign wr_addr     = elem_addr(wr_row_i[IDX_W-1:0], wr_col_i[IDX_W-1:0]);
  assign wr_data     = sext_elem(wr_value_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && wr_in_range) begin
      store_a[wr_addr] <= wr_data;
    end
    if (cmd_i.wr_b && wr_in_range) begin
      store_b[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= store_a[elem_addr(cmd_i.rd_row, cmd_i.rd_k)];
      b_rd_q <= store_b[elem_addr(cmd_i.rd_k, cmd_i.rd_col)];
    end
  end

  // low half of the product is the same for signed and unsigned operands
  assign mul_d = a_rd_q * b_rd_q;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (mul_vld_q) begin
      acc_d = acc_q + mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_en;
      mul_vld_q <= rd_vld_q;
    end
  end

  assign sts_o.pipe_busy = rd_vld_q | mul_vld_q;
  assign product_o       = acc_q;

endmodule

// ===== hw/rtl/imm_ctrl.sv =====
// ----------------------------------------------------------------------------
// imm_ctrl
// Dimension registers and the sequencer that walks rows, columns and the
// inner dimension.
// ----------------------------------------------------------------------------
module imm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [imm_pkg::KIND_W-1:0]    in_kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [imm_pkg::FLD_W-1:0]     out_row_o,
  output logic [imm_pkg::FLD_W-1:0]     out_col_o,
  output logic                          out_last_o,
  output imm_pkg::imm_cmd_t             cmd_o,
  input  imm_pkg::imm_sts_t             sts_i
);
  import imm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [DIM_W-1:0] nr, nk, nc;
  logic             in_acc, out_acc;
  logic             k_end, c_end, r_end;

  assign nr = clamp_dim(rows_a_q);
  assign nk = clamp_dim(inner_dim_q);
  assign nc = clamp_dim(cols_b_q);

  assign k_end = (DIM_W'(k_q) == nk - DIM_W'(1));
  assign c_end = (DIM_W'(c_q) == nc - DIM_W'(1));
  assign r_end = (DIM_W'(r_q) == nr - DIM_W'(1));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  assign out_row_o  = FLD_W'(r_q);
  assign out_col_o  = FLD_W'(c_q);
  assign out_last_o = r_end & c_end;

  always_comb begin
    cmd_o.wr_a    = in_acc && (in_kind_i == KIND_WR_A);
    cmd_o.wr_b    = in_acc && (in_kind_i == KIND_WR_B);
    cmd_o.rd_en   = (state_q == ST_ISSUE);
    cmd_o.acc_clr = (state_q == ST_ISSUE) && (k_q == '0);
    cmd_o.rd_row  = r_q;
    cmd_o.rd_col  = c_q;
    cmd_o.rd_k    = k_q;
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_kind_i == KIND_COMPUTE)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_end) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (r_end && c_end) begin
            state_d = ST_IDLE;
          end else if (c_end) begin
            c_d     = '0;
            r_d     = r_q + IDX_W'(1);
            state_d = ST_ISSUE;
          end else begin
            c_d     = c_q + IDX_W'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROWS_A:    rows_a_q    <= cfg_wdata_i;
          REG_INNER_DIM: inner_dim_q <= cfg_wdata_i;
          REG_COLS_B:    cols_b_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed integer matrix multiplier with element stores and a sequenced
// multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Requests on in_i either load one element of A or B (kind 0 / 1, at row,
// col; the value is sign extended from ELEM_WIDTH bits, indexes beyond the
// store are dropped) or start a compute run (kind 2); kind 3 is ignored.
// Write requests are taken one per cycle while no compute run is active.
// A compute run emits rows_a*cols_b results on out_o in row-major order,
// last set on the final one; every element is the 32-bit wrapped sum over
// inner_dim of A[r][k]*B[k][c]. Per result, each single-ported store is read
// once per cycle over the inner dimension, the read / multiply / accumulate
// pipeline drains and the output register holds the result until taken.
// No new request is taken until the last result of a run has gone.
// Dimensions of 0 act as 1, above MAX_DIM as MAX_DIM. Configure only while
// idle. Reading an element never written since reset gives an undefined
// result. No clearing pass after reset.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  imm_in_if.sink                        in_i,
  imm_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import imm_pkg::*;

  imm_cmd_t cmd;
  imm_sts_t sts;

  // sequencer: dimension registers, handshakes and loop counters
  imm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_kind_i   (in_i.kind),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .out_last_o  (out_o.last),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // stores and MAC pipeline; the accumulator doubles as the result register
  imm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .wr_row_i   (in_i.row),
    .wr_col_i   (in_i.col),
    .wr_value_i (in_i.value),
    .product_o  (out_o.product)
  );

endmodule

// ===== hw/rtl/imm_checker.sv =====
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks of the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module imm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [imm_pkg::KIND_W-1:0]    in_kind_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_last_i,
  input logic [imm_pkg::DATA_W-1:0]    out_product_i
);
  import imm_pkg::*;

  // one request at a time: never taking requests while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("request taken while result pending");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == KIND_COMPUTE)
      |=> (!in_ready_i && !out_valid_i))
    else $error("compute request did not start a run");

  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i != KIND_COMPUTE) |=> in_ready_i)
    else $error("write request stalled the block");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("run did not end after last result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_product_i)))
    else $error("stalled result changed");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_last_i    (out_o.last),
  .out_product_i (out_o.product)
);
